>>> rtl/htfd_pkg.sv
// htfd_pkg: shared types, constants and the crc-8 update function for the
// humidity/temperature frame decoder; no dependencies
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic [2:0]         POS_STATUS  = 3'd0;
    localparam logic [2:0]         POS_HUM_HI  = 3'd1;
    localparam logic [2:0]         POS_HUM_MID = 3'd2;
    localparam logic [2:0]         POS_SPLIT   = 3'd3;
    localparam logic [2:0]         POS_TMP_MID = 3'd4;
    localparam logic [2:0]         POS_TMP_LO  = 3'd5;
    localparam logic [2:0]         POS_CRC     = 3'd6;
    localparam logic [13:0]        HUM_SCALE   = 14'd10000;
    localparam logic [14:0]        TEMP_SCALE  = 15'd20000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

    typedef struct packed {
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic        crc_ok;
    } t_frame;

    // one byte through the msb-first crc-8, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/htfd_frame.sv
// htfd_frame: byte position tracking, running crc and raw field assembly;
// holds a finished frame in a register until the scaling stage takes it
// depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    input  logic                i_take,
    output logic                o_frm_valid,
    output htfd_pkg::t_frame    o_frm
);
    import htfd_pkg::*;

    logic [2:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic [19:0] r_hum,  n_hum;
    logic [19:0] r_tmp,  n_tmp;
    logic        r_frm_valid, n_frm_valid;
    t_frame      r_frm,  n_frm;

    logic [2:0]  w_pos;
    logic [7:0]  w_crc;

    always_comb begin
        // frame start restarts position and crc before the word is taken
        w_pos = i_frame_start ? POS_STATUS : r_pos;
        w_crc = i_frame_start ? CRC_INIT : r_crc;

        n_pos       = r_pos;
        n_crc       = r_crc;
        n_hum       = r_hum;
        n_tmp       = r_tmp;
        n_frm       = r_frm;
        n_frm_valid = r_frm_valid && !i_take;

        if (i_accept) begin
            if (w_pos < POS_CRC) begin
                n_crc = crc8_update(w_crc, i_rx_byte);
                n_pos = w_pos + 3'd1;
                unique case (w_pos)
                    POS_HUM_HI:  n_hum = {i_rx_byte, r_hum[11:0]};
                    POS_HUM_MID: n_hum = {r_hum[19:12], i_rx_byte, r_hum[3:0]};
                    POS_SPLIT: begin
                        n_hum = {r_hum[19:4], i_rx_byte[7:4]};
                        n_tmp = {i_rx_byte[3:0], r_tmp[15:0]};
                    end
                    POS_TMP_MID: n_tmp = {r_tmp[19:16], i_rx_byte, r_tmp[7:0]};
                    POS_TMP_LO:  n_tmp = {r_tmp[19:8], i_rx_byte};
                    default: begin
                    end
                endcase
            end else begin
                n_frm.hum_raw  = r_hum;
                n_frm.temp_raw = r_tmp;
                n_frm.crc_ok   = (w_crc == i_rx_byte);
                n_frm_valid    = 1'b1;
                n_pos          = POS_STATUS;
                n_crc          = CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_STATUS;
            r_crc       <= CRC_INIT;
            r_hum       <= 20'd0;
            r_tmp       <= 20'd0;
            r_frm_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_hum       <= n_hum;
            r_tmp       <= n_tmp;
            r_frm_valid <= n_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frm <= n_frm;
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

endmodule

>>> rtl/htfd_scale.sv
// htfd_scale: converts raw humidity and temperature to hundredths and holds
// the result word in the output register
// depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_frm_valid,
    input  htfd_pkg::t_frame    i_frm,
    input  logic                i_stall,
    output logic                o_take,
    output logic                o_valid,
    output logic [13:0]         o_humidity_centi,
    output logic signed [14:0]  o_temperature_centi,
    output logic                o_crc_ok
);
    import htfd_pkg::*;

    logic                r_valid;
    logic [13:0]         r_hum,  n_hum;
    logic signed [14:0]  r_tmp,  n_tmp;
    logic                r_ok;

    logic                w_load;
    logic [33:0]         w_hum_prod;
    logic [34:0]         w_tmp_prod;
    logic signed [15:0]  w_tmp_floor;
    logic signed [15:0]  w_tmp_trunc;

    assign w_load = !r_valid || !i_stall;
    assign o_take = i_frm_valid && w_load;

    assign w_hum_prod  = 34'(i_frm.hum_raw) * 34'(HUM_SCALE);
    assign w_tmp_prod  = 35'(i_frm.temp_raw) * 35'(TEMP_SCALE);
    // offset is a whole multiple of 2^20, so floor is the high part minus 5000
    assign w_tmp_floor = $signed({1'b0, w_tmp_prod[34:20]}) - TEMP_OFFSET;
    // round negative values toward zero when fraction bits are left over
    assign w_tmp_trunc = w_tmp_floor
                       + $signed(16'(w_tmp_floor[15] && (w_tmp_prod[19:0] != 20'd0)));

    always_comb begin
        if (i_frm.crc_ok) begin
            n_hum = w_hum_prod[33:20];
            n_tmp = w_tmp_trunc[14:0];
        end else begin
            n_hum = 14'd0;
            n_tmp = 15'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hum <= n_hum;
            r_tmp <= n_tmp;
            r_ok  <= i_frm.crc_ok;
        end
    end

    assign o_valid             = r_valid;
    assign o_humidity_centi    = r_hum;
    assign o_temperature_centi = r_tmp;
    assign o_crc_ok            = r_ok;

endmodule

>>> rtl/humidity_temp_frame_decoder_core.sv
// humidity_temp_frame_decoder_core: top level of the frame decoder
// depends on htfd_pkg, htfd_frame, htfd_scale
//
// usage:
//   input channel: one frame byte per word on i_rx_byte, i_frame_start high
//   on the status byte; a word is taken when i_valid is high and o_stall low
//   a frame is status, five data bytes, crc byte; the crc-8 (poly 0x31,
//   init 0xff) runs over the first six bytes
//   output channel: one result word per completed frame, taken when o_valid
//   is high and i_stall low; humidity and temperature are 0 on crc failure
//   throughput: one word per cycle while o_stall is low
//   after the crc byte is taken, the result passes the frame register and
//   then the scaling register
//   reset: byte position 0, crc 0xff, raw fields 0, no result pending
//   stall: the output register holds its word; a second finished frame waits
//   in the frame register, and only then is o_stall raised to the sender
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [13:0]         o_humidity_centi,
    output logic signed [14:0]  o_temperature_centi,
    output logic                o_crc_ok
);
    import htfd_pkg::*;

    logic   w_accept;
    logic   w_take;
    logic   w_frm_valid;
    t_frame w_frm;

    assign o_stall  = w_frm_valid && !w_take;
    assign w_accept = i_valid && !o_stall;

    htfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_take        (w_take),
        .o_frm_valid   (w_frm_valid),
        .o_frm         (w_frm)
    );

    htfd_scale u_scale (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_frm_valid         (w_frm_valid),
        .i_frm               (w_frm),
        .i_stall             (i_stall),
        .o_take              (w_take),
        .o_valid             (o_valid),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_centi (o_temperature_centi),
        .o_crc_ok            (o_crc_ok)
    );

endmodule

>>> tb/humidity_temp_frame_decoder_core_test.sv
// self-checking testbench for humidity_temp_frame_decoder_core: feeds frames byte by byte,
// predicts crc check and scaled readings per frame, compares every result word
// depends on rtl/humidity_temp_frame_decoder_core.sv (and htfd_pkg through it)
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_core_test;

    localparam logic [7:0]  GEN_POLY     = 8'h31;
    localparam logic [7:0]  CRC_SEED     = 8'hFF;
    localparam logic [2:0]  AT_STATUS    = 3'd0;
    localparam logic [2:0]  AT_HUM_HI    = 3'd1;
    localparam logic [2:0]  AT_HUM_MID   = 3'd2;
    localparam logic [2:0]  AT_SPLIT     = 3'd3;
    localparam logic [2:0]  AT_TEMP_MID  = 3'd4;
    localparam logic [2:0]  AT_TEMP_LO   = 3'd5;
    localparam logic [2:0]  AT_CHECK     = 3'd6;
    localparam longint      RAW_ONE      = 64'sd1048576;
    localparam longint      HUM_FULL     = 64'sd10000;
    localparam longint      TEMP_SPAN    = 64'sd20000;
    localparam longint      TEMP_BIAS    = 64'sd5000;
    localparam int          DIRECTED_END = 24;
    localparam int          BURST_END    = DIRECTED_END + 250;
    localparam int          TOTAL_WORDS  = 900;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          IDLE_PCT     = 26;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_frame_word;

    typedef struct packed {
        logic [13:0]        humidity;
        logic signed [14:0] temperature;
        logic               crc_ok;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [13:0]        o_humidity_centi;
    logic signed [14:0] o_temperature_centi;
    logic               o_crc_ok;

    t_frame_word word_q[$];
    t_reading    reading_q[$];
    t_frame_word next_word;
    t_reading    want;

    // predictor state
    logic [2:0]  frame_pos = AT_STATUS;
    logic [7:0]  frame_crc = CRC_SEED;
    logic [19:0] hum_raw = '0;
    logic [19:0] temp_raw = '0;

    int words_queued = 0;
    int words_taken = 0;
    int mismatch_count = 0;
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    humidity_temp_frame_decoder_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_centi (o_temperature_centi),
        .o_crc_ok            (o_crc_ok)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // bit-serial form of the msb-first crc-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ data[k];
            r = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ GEN_POLY;
            end
        end
        return r;
    endfunction

    task automatic decode_word(input logic [7:0] b, input logic start);
        t_reading r;
        longint   hum;
        longint   num;
        longint   quo;
        if (start) begin
            frame_pos = AT_STATUS;
            frame_crc = CRC_SEED;
        end
        if (frame_pos < AT_CHECK) begin
            frame_crc = crc8_step(frame_crc, b);
            case (frame_pos)
                AT_HUM_HI:   hum_raw[19:12] = b;
                AT_HUM_MID:  hum_raw[11:4] = b;
                AT_SPLIT: begin
                    hum_raw[3:0] = b[7:4];
                    temp_raw[19:16] = b[3:0];
                end
                AT_TEMP_MID: temp_raw[15:8] = b;
                AT_TEMP_LO:  temp_raw[7:0] = b;
                default: ;
            endcase
            frame_pos = frame_pos + 3'd1;
        end else begin
            r = '0;
            r.crc_ok = (frame_crc == b);
            if (r.crc_ok) begin
                hum = (longint'(hum_raw) * HUM_FULL) / RAW_ONE;
                num = longint'(temp_raw) * TEMP_SPAN - TEMP_BIAS * RAW_ONE;
                // signed division truncates toward zero
                quo = num / RAW_ONE;
                r.humidity = hum[13:0];
                r.temperature = quo[14:0];
            end
            reading_q.push_back(r);
            frame_pos = AT_STATUS;
            frame_crc = CRC_SEED;
        end
    endtask

    task automatic queue_word(input logic [7:0] b, input logic start);
        t_frame_word w;
        w.rx_byte = b;
        w.frame_start = start;
        word_q.push_back(w);
        words_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] status, input logic [39:0] payload,
                               input logic start, input logic bad_crc);
        logic [7:0] fb[7];
        logic [7:0] crc;
        fb[0] = status;
        for (int i = 1; i < 6; i++) begin
            fb[i] = payload[47 - 8 * i -: 8];
        end
        crc = CRC_SEED;
        for (int i = 0; i < 6; i++) begin
            crc = crc8_step(crc, fb[i]);
        end
        fb[6] = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
        for (int i = 0; i < 7; i++) begin
            queue_word(fb[i], (i == 0) ? start : 1'b0);
        end
    endtask

    task automatic queue_partial(input int count);
        for (int i = 0; i < count; i++) begin
            queue_word(8'($urandom), i == 0);
        end
    endtask

    task automatic wait_words_taken();
        while (words_taken != words_queued) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_readings_done();
        while (reading_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic queue_random_until(input int target);
        int  pick;
        bit  aligned;
        aligned = 1'b0;
        while (words_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                // good frame; a start flag is optional only when the position is known to be 0
                queue_frame(8'($urandom), {8'($urandom), 32'($urandom)},
                            aligned ? 1'($urandom) : 1'b1, 1'b0);
                aligned = 1'b1;
            end else if (pick < 80) begin
                queue_frame(8'($urandom), {8'($urandom), 32'($urandom)}, 1'b1, 1'b1);
                aligned = 1'b1;
            end else if (pick < 90) begin
                queue_partial($urandom_range(1, 6));
                aligned = 1'b0;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_word(8'($urandom), 1'($urandom));
                end
                aligned = 1'b0;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_word(i_rx_byte, i_frame_start);
                words_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= next_word.rx_byte;
                    i_frame_start <= next_word.frame_start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (reading_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result word: hum %0d temp %0d crc_ok %0b",
                             o_humidity_centi, o_temperature_centi, o_crc_ok);
                end
            end else begin
                want = reading_q.pop_front();
                if (o_humidity_centi !== want.humidity
                        || o_temperature_centi !== want.temperature
                        || o_crc_ok !== want.crc_ok) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        // expected / actual pairs
                        $display("mismatch: hum %0d/%0d temp %0d/%0d crc_ok %0b/%0b",
                                 want.humidity, o_humidity_centi,
                                 want.temperature, o_temperature_centi,
                                 want.crc_ok, o_crc_ok);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // no start flag on the very first status byte
        queue_frame(8'h1C, 40'h00_0000_0000, 1'b0, 1'b0);
        // partial frame, then a new start drops it; full-scale readings
        queue_partial(3);
        queue_frame(8'h18, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
        // bad crc right after a completed frame, no start flag
        queue_frame(8'h98, 40'h80_0008_0000, 1'b0, 1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_words_taken();
        // sender pauses here until every result is in
        wait_readings_done();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_until(BURST_END);
        hold_seq = hold_seq + 1;
        wait_words_taken();

        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
        queue_random_until(TOTAL_WORDS);
        wait_words_taken();
        wait_readings_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && reading_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
